/* hdl/mvbo_pkg.sv */
// shared constants and types for the moving variance baseline offset unit
package mvbo_pkg;

    // window and sample geometry
    localparam int WINDOW_SHIFT = 7;
    localparam int SAMPLE_BITS  = 12;
    localparam int RING_DEPTH   = 1 << WINDOW_SHIFT;

    // running sums and derived values
    localparam int SUM_W = SAMPLE_BITS + WINDOW_SHIFT;
    localparam int SQ_W  = 2 * SAMPLE_BITS + WINDOW_SHIFT;
    localparam int VAR_W = SQ_W - WINDOW_SHIFT;

    // port field widths
    localparam int DEV_W       = 16;
    localparam int MEAN_W      = 12;
    localparam int VAR_FIELD_W = 23;
    localparam int THRESH_W    = 23;
    localparam int CMP_W       = (VAR_W > THRESH_W) ? VAR_W : THRESH_W;
    localparam int DIFF_W      = SAMPLE_BITS + 1;

    // register reset and special output codes
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1000);
    localparam logic signed [DEV_W-1:0] NO_BASELINE_CODE = DEV_W'(16384);
    localparam int DEV_MAX = 32767;
    localparam int DEV_MIN = -32768;

    // result queue sizing
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one result beat
    typedef struct packed {
        logic signed [DEV_W-1:0]   deviation;
        logic [MEAN_W-1:0]         window_mean;
        logic [VAR_FIELD_W-1:0]    window_variance;
    } result_t;

endpackage

/* hdl/moving_variance_baseline_offset_unit.sv */
// Moving-window variance with baseline capture for one strain-gauge axis. The
// unit takes one sample beat per clock while in_stall is low and returns one
// result beat per sample, in order. The 128-sample window is a chain of
// shifting cells; a four-stage pipeline (captured beat, squares, running sums,
// sum times mean) feeds the variance and baseline logic, and an 8-entry result
// queue sets how far the output may fall behind: in_stall rises once 8 beats
// are taken but not yet delivered. A zero sample clears the baseline, leaves
// the window alone and returns all zeros.
// The threshold register may be written whenever no beats are outstanding.
module moving_variance_baseline_offset_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mvbo_pkg::THRESH_W-1:0]       variance_threshold,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mvbo_pkg::SAMPLE_BITS-1:0]    sample,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mvbo_pkg::DEV_W-1:0]   deviation,
    output logic [mvbo_pkg::MEAN_W-1:0]         window_mean,
    output logic [mvbo_pkg::VAR_FIELD_W-1:0]    window_variance
);

    logic [mvbo_pkg::THRESH_W-1:0] thresh_reg;
    logic [mvbo_pkg::THRESH_W-1:0] thresh_next;
    logic [mvbo_pkg::QCNT_W-1:0]   count_reg;
    logic [mvbo_pkg::QCNT_W-1:0]   count_next;
    logic                          acc;
    logic                          pop;
    logic                          shift;
    logic [mvbo_pkg::SAMPLE_BITS-1:0] tail;
    logic                          res_valid;
    mvbo_pkg::result_t             res;
    mvbo_pkg::result_t             head;

    // threshold register
    assign cfg_ready   = 1'b1;
    assign thresh_next = cfg_valid ? variance_threshold : thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= mvbo_pkg::THRESH_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

    // beats taken but not yet delivered
    assign acc        = in_valid && !in_stall;
    assign pop        = out_valid && !out_stall;
    assign in_stall   = (count_reg == mvbo_pkg::QCNT_W'(mvbo_pkg::QUEUE_DEPTH));
    assign count_next = count_reg + mvbo_pkg::QCNT_W'(acc) - mvbo_pkg::QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // window shifts only on nonzero samples
    assign shift = acc && (sample != '0);

    mvbo_chain u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .din   (sample),
        .tail  (tail)
    );

    mvbo_stats u_stats
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .sample    (sample),
        .old       (tail),
        .threshold (thresh_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mvbo_result_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .rd       (pop),
        .rd_valid (out_valid),
        .rd_data  (head)
    );

    // output fields
    assign deviation       = head.deviation;
    assign window_mean     = head.window_mean;
    assign window_variance = head.window_variance;

    // every taken beat leaves the pipeline through the s1 to s4 valid registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> ##4 res_valid)
        else $error("result beat missing after pipeline latency");

    // a clear sample yields an all-zero result
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && sample == '0) |-> ##4 (res_valid && res.deviation == '0
            && res.window_mean == '0 && res.window_variance == '0))
        else $error("clear sample gave a nonzero result");

    // a queued result always has an outstanding credit
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_reg != '0))
        else $error("result queued without outstanding beat");

endmodule

/* hdl/mvbo_cell.sv */
// one sample cell of the window shift chain
module mvbo_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift,
    input  logic [mvbo_pkg::SAMPLE_BITS-1:0]    din,
    output logic [mvbo_pkg::SAMPLE_BITS-1:0]    q
);

    logic [mvbo_pkg::SAMPLE_BITS-1:0] q_reg;
    logic [mvbo_pkg::SAMPLE_BITS-1:0] q_next;

    // take the neighbor's sample on a shift
    always_comb
    begin
        q_next = shift ? din : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* hdl/mvbo_chain.sv */
// window of past samples as a row of shifting cells, oldest at the tail
module mvbo_chain
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift,
    input  logic [mvbo_pkg::SAMPLE_BITS-1:0]    din,
    output logic [mvbo_pkg::SAMPLE_BITS-1:0]    tail
);

    logic [mvbo_pkg::SAMPLE_BITS-1:0] taps [mvbo_pkg::RING_DEPTH];

    // cell 0 takes the new sample, each later cell its left neighbor
    for (genvar i = 0; i < mvbo_pkg::RING_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            mvbo_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   (din),
                .q     (taps[i])
            );
        end
        else
        begin : g_body
            mvbo_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   (taps[i-1]),
                .q     (taps[i])
            );
        end
    end

    // the sample that leaves the window on the next shift
    assign tail = taps[mvbo_pkg::RING_DEPTH-1];

endmodule

/* hdl/mvbo_stats.sv */
// statistics pipeline: squares, running sums, sum times mean, variance and baseline
module mvbo_stats
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                acc,
    input  logic [mvbo_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic [mvbo_pkg::SAMPLE_BITS-1:0]    old,
    input  logic [mvbo_pkg::THRESH_W-1:0]       threshold,
    output logic                                res_valid,
    output mvbo_pkg::result_t                   res
);

    localparam int SB = mvbo_pkg::SAMPLE_BITS;
    localparam int PW = 2 * mvbo_pkg::SAMPLE_BITS;

    // stage 1: captured beat
    logic                   s1_valid_reg;
    logic                   s1_clear_reg;
    logic [SB-1:0]          s1_sample_reg;
    logic [SB-1:0]          s1_old_reg;

    // stage 2: squares
    logic                   s2_valid_reg;
    logic                   s2_clear_reg;
    logic [SB-1:0]          s2_sample_reg;
    logic [SB-1:0]          s2_old_reg;
    logic [2*SB-1:0]        s2_sq_new_reg;
    logic [2*SB-1:0]        s2_sq_old_reg;

    // stage 3: running sums
    logic                   s3_valid_reg;
    logic                   s3_clear_reg;
    logic [SB-1:0]          s3_sample_reg;
    logic [mvbo_pkg::SUM_W-1:0] sum_reg;
    logic [mvbo_pkg::SUM_W-1:0] sum_next;
    logic [mvbo_pkg::SQ_W-1:0]  sqsum_reg;
    logic [mvbo_pkg::SQ_W-1:0]  sqsum_next;
    logic [SB-1:0]          mean;

    // stage 4: sum times mean
    logic                   s4_valid_reg;
    logic                   s4_clear_reg;
    logic [SB-1:0]          s4_sample_reg;
    logic [SB-1:0]          s4_mean_reg;
    logic [mvbo_pkg::SQ_W-1:0]  s4_sqsum_reg;
    logic [mvbo_pkg::SQ_W-1:0]  s4_prod_reg;
    logic [mvbo_pkg::SQ_W-1:0]  prod_next;

    // final stage: variance and baseline
    logic [SB-1:0]          baseline_reg;
    logic [SB-1:0]          baseline_next;
    logic [SB-1:0]          baseline_new;
    logic [mvbo_pkg::SQ_W-1:0]  var_diff;
    logic [mvbo_pkg::CMP_W-1:0] variance;
    logic                   below;
    logic signed [mvbo_pkg::DIFF_W-1:0] dev_diff;
    logic signed [31:0]     dev_wide;
    logic signed [mvbo_pkg::DEV_W-1:0]  dev_sat;

    // valid flags travel with the beat; the clear flags go with the payload below
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        s1_clear_reg  <= (sample == '0);
        s1_sample_reg <= sample;
        s1_old_reg    <= old;

        s2_clear_reg  <= s1_clear_reg;
        s2_sample_reg <= s1_sample_reg;
        s2_old_reg    <= s1_old_reg;
        s2_sq_new_reg <= PW'(s1_sample_reg) * PW'(s1_sample_reg);
        s2_sq_old_reg <= PW'(s1_old_reg) * PW'(s1_old_reg);

        s3_clear_reg  <= s2_clear_reg;
        s3_sample_reg <= s2_sample_reg;

        s4_clear_reg  <= s3_clear_reg;
        s4_sample_reg <= s3_sample_reg;
        s4_mean_reg   <= mean;
        s4_sqsum_reg  <= sqsum_reg;
        s4_prod_reg   <= prod_next;
    end

    // running sums swap the leaving sample for the new one
    always_comb
    begin
        sum_next   = sum_reg;
        sqsum_next = sqsum_reg;
        if (s2_valid_reg && !s2_clear_reg)
        begin
            sum_next   = sum_reg + mvbo_pkg::SUM_W'(s2_sample_reg)
                       - mvbo_pkg::SUM_W'(s2_old_reg);
            sqsum_next = sqsum_reg + mvbo_pkg::SQ_W'(s2_sq_new_reg)
                       - mvbo_pkg::SQ_W'(s2_sq_old_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            sqsum_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            sqsum_reg <= sqsum_next;
        end
    end

    // window mean and its product with the sum
    assign mean      = sum_reg[mvbo_pkg::SUM_W-1 -: SB];
    assign prod_next = mvbo_pkg::SQ_W'(sum_reg) * mvbo_pkg::SQ_W'(mean);

    // variance and threshold compare on the unsaturated value
    always_comb
    begin
        var_diff = s4_sqsum_reg - s4_prod_reg;
        variance = mvbo_pkg::CMP_W'(var_diff >> mvbo_pkg::WINDOW_SHIFT);
        below    = variance < mvbo_pkg::CMP_W'(threshold);
    end

    // baseline latch while none is held
    always_comb
    begin
        baseline_new  = (baseline_reg == '0 && below) ? s4_mean_reg : baseline_reg;
        baseline_next = baseline_reg;
        if (s4_valid_reg)
        begin
            baseline_next = s4_clear_reg ? '0 : baseline_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
        end
        else
        begin
            baseline_reg <= baseline_next;
        end
    end

    // deviation with saturation to the field range
    always_comb
    begin
        dev_diff = $signed({1'b0, s4_sample_reg}) - $signed({1'b0, baseline_new});
        dev_wide = 32'(dev_diff);
        if (dev_wide > 32'(mvbo_pkg::DEV_MAX))
        begin
            dev_sat = mvbo_pkg::DEV_W'(mvbo_pkg::DEV_MAX);
        end
        else if (dev_wide < 32'(mvbo_pkg::DEV_MIN))
        begin
            dev_sat = mvbo_pkg::DEV_W'(mvbo_pkg::DEV_MIN);
        end
        else
        begin
            dev_sat = dev_wide[mvbo_pkg::DEV_W-1:0];
        end
    end

    // result beat, all zero on a clear
    always_comb
    begin
        res = '0;
        if (!s4_clear_reg)
        begin
            res.deviation   = (baseline_new != '0) ? dev_sat : mvbo_pkg::NO_BASELINE_CODE;
            res.window_mean = mvbo_pkg::MEAN_W'(s4_mean_reg);
            if (variance > mvbo_pkg::CMP_W'({mvbo_pkg::VAR_FIELD_W{1'b1}}))
            begin
                res.window_variance = '1;
            end
            else
            begin
                res.window_variance = mvbo_pkg::VAR_FIELD_W'(variance);
            end
        end
    end

    assign res_valid = s4_valid_reg;

endmodule

/* hdl/mvbo_result_queue.sv */
// small queue of finished result beats in front of the output port
module mvbo_result_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    input  mvbo_pkg::result_t   wr_data,
    input  logic                rd,
    output logic                rd_valid,
    output mvbo_pkg::result_t   rd_data
);

    mvbo_pkg::result_t entries [mvbo_pkg::QUEUE_DEPTH];

    logic [mvbo_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mvbo_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [mvbo_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mvbo_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [mvbo_pkg::QCNT_W-1:0] fill_reg;
    logic [mvbo_pkg::QCNT_W-1:0] fill_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + mvbo_pkg::QCNT_W'(wr_valid) - mvbo_pkg::QCNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_valid = (fill_reg != '0);
    assign rd_data  = entries[rd_ptr_reg];

endmodule
